// ===== hw/rtl/mbp_pkg.sv =====
// Package: transaction types and constants of the MSB-first bit packer.
`timescale 1ns / 1ps

package mbp_pkg;

   localparam int MAX_CODE_BITS = 24;
   localparam int QUEUE_DEPTH   = 4;

   localparam logic FUNC_PUT   = 1'b0;
   localparam logic FUNC_FLUSH = 1'b1;

   typedef struct packed {
      logic        func;
      logic [23:0] code_value;
      logic [4:0]  bit_count;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } rsp_type;

endpackage

// ===== hw/rtl/mbp_front.sv =====
// Front end: takes put/flush transactions, packs bits, queues completed byte groups.
`timescale 1ns / 1ps

module mbp_front #(
   parameter int MaxCodeBits = 24,
   parameter int EntryW      = 26
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  mbp_pkg::req_type  req_data,
   output logic              q_push,
   input  logic              q_full,
   output logic [EntryW-1:0] q_data
);
   import mbp_pkg::*;

   localparam int AccW     = MaxCodeBits + 7;
   localparam int MaxBytes = AccW / 8;
   localparam int BytesW   = 8 * MaxBytes;
   localparam int CntW     = $clog2(MaxBytes + 1);
   localparam int TotW     = $clog2(AccW + 1);

   logic [6:0]      partial_ff, partial_in;
   logic [2:0]      pending_ff, pending_in;
   logic [4:0]      n_eff;
   logic [AccW-1:0] vmask, masked, acc, aligned;
   logic [TotW-1:0] total, shamt;
   logic [CntW-1:0] nbytes;
   logic            accept;

   always_comb begin
      if (req_data.func == FUNC_FLUSH) begin
         n_eff = 5'd0;
      end else if (req_data.bit_count > 5'(MaxCodeBits)) begin
         n_eff = 5'(MaxCodeBits);
      end else begin
         n_eff = req_data.bit_count;
      end
      vmask   = ~({AccW{1'b1}} << n_eff);
      masked  = AccW'(req_data.code_value[MaxCodeBits-1:0]) & vmask;
      acc     = (AccW'(partial_ff) << n_eff) | masked;
      total   = TotW'(pending_ff) + TotW'(n_eff);
      shamt   = TotW'(AccW) - total;
      aligned = acc << shamt;
      if (req_data.func == FUNC_FLUSH) begin
         nbytes     = CntW'(pending_ff != 3'd0);
         pending_in = 3'd0;
         partial_in = 7'd0;
      end else begin
         nbytes     = CntW'(total >> 3);
         pending_in = total[2:0];
         partial_in = acc[6:0] & ~(7'h7F << total[2:0]);
      end
   end

   assign accept   = req_push && !q_full;
   assign req_full = q_full;
   assign q_push   = accept && (nbytes != '0);
   assign q_data   = {nbytes, aligned[AccW-1 -: BytesW]};

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= 7'd0;
         pending_ff <= 3'd0;
      end else if (accept) begin
         partial_ff <= partial_in;
         pending_ff <= pending_in;
      end
   end

endmodule

// ===== hw/rtl/mbp_queue.sv =====
// Short FIFO of byte groups between front and back end.
`timescale 1ns / 1ps

module mbp_queue #(
   parameter int Width = 26,
   parameter int Depth = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [Width-1:0] wr_data,
   input  logic             pop,
   output logic             empty,
   output logic [Width-1:0] rd_data
);
   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   logic [Width-1:0] slot_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CntW'(Depth));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hw/rtl/mbp_back.sv =====
// Back end: serializes queued byte groups into output bytes with last flag.
`timescale 1ns / 1ps

module mbp_back #(
   parameter int MaxCodeBits = 24,
   parameter int EntryW      = 26
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   output logic              q_pop,
   input  logic [EntryW-1:0] q_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output mbp_pkg::rsp_type  rsp_data
);
   import mbp_pkg::*;

   localparam int AccW     = MaxCodeBits + 7;
   localparam int MaxBytes = AccW / 8;
   localparam int BytesW   = 8 * MaxBytes;
   localparam int CntW     = $clog2(MaxBytes + 1);

   logic [BytesW-1:0] bytes_ff, bytes_in;
   logic [CntW-1:0]   left_ff, left_in;
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff, out_in;
   logic              advance, move, move_last, load;

   assign advance   = !out_valid_ff || rsp_pop;
   assign move      = advance && (left_ff != '0);
   assign move_last = move && (left_ff == CntW'(1));
   assign load      = !q_empty && ((left_ff == '0) || move_last);
   assign q_pop     = load;

   always_comb begin
      bytes_in     = bytes_ff;
      left_in      = left_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (move) begin
         bytes_in = bytes_ff << 8;
         left_in  = left_ff - 1'b1;
         out_in   = '{out_byte: bytes_ff[BytesW-1 -: 8], last: (left_ff == CntW'(1))};
      end
      if (advance) begin
         out_valid_in = move;
      end
      if (load) begin
         bytes_in = q_data[BytesW-1:0];
         left_in  = q_data[EntryW-1 -: CntW];
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
      out_ff   <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         left_ff      <= left_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// ===== hw/rtl/msb_first_bit_packer.sv =====
// Top level: MSB-first variable-length bit packer.
//
//   channel | ports                                | direction
//   req     | req_push, req_full, req_data         | put/flush transactions in
//   rsp     | rsp_pop, rsp_empty, rsp_data         | packed bytes out, last on final
//
// A transaction is taken every cycle while the group queue has room; its
// bytes (up to three) leave one per cycle from a registered output while
// rsp_pop takes them, so the output port sets the sustained rate. A group
// passes the queue and the back end's byte register before the output.
// Synchronous reset clears the pending bits, the queue and the output. A
// stalled output fills the queue, and req_full then holds the input.
`timescale 1ns / 1ps

module msb_first_bit_packer #(
   parameter int MaxCodeBits = mbp_pkg::MAX_CODE_BITS,
   parameter int QueueDepth  = mbp_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  mbp_pkg::req_type req_data,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output mbp_pkg::rsp_type rsp_data
);
   import mbp_pkg::*;

   localparam int AccW     = MaxCodeBits + 7;
   localparam int MaxBytes = AccW / 8;
   localparam int EntryW   = 8 * MaxBytes + $clog2(MaxBytes + 1);

   logic              q_push, q_full, q_pop, q_empty;
   logic [EntryW-1:0] q_wr_data, q_rd_data;

   mbp_front #(
      .MaxCodeBits(MaxCodeBits),
      .EntryW     (EntryW)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_data(req_data),
      .q_push  (q_push),
      .q_full  (q_full),
      .q_data  (q_wr_data)
   );

   mbp_queue #(
      .Width(EntryW),
      .Depth(QueueDepth)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .full   (q_full),
      .wr_data(q_wr_data),
      .pop    (q_pop),
      .empty  (q_empty),
      .rd_data(q_rd_data)
   );

   mbp_back #(
      .MaxCodeBits(MaxCodeBits),
      .EntryW     (EntryW)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .q_data   (q_rd_data),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .rsp_data (rsp_data)
   );

endmodule
